FILE: sv/ssa_pkg.sv
// Shared types, field widths, reset values and codes of the shelf slot allocator.
// No dependencies; every other file imports this package.
package ssa_pkg;

  localparam int NUM_SHELVES_DEF = 8;
  localparam int NUM_LEVELS_DEF  = 4;

  localparam int CLASS_W     = 2;
  localparam int VOL_W       = 11;
  localparam int WGT_W       = 11;
  localparam int CAP_W       = 16;
  localparam int SHELF_W     = 3;
  localparam int LEVEL_W     = 2;
  localparam int COUNT_W     = 10;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = 10'd1023;
  localparam logic [SHELF_W-1:0] RESERVED_RST  = 3'd0;
  localparam logic [VOL_W-1:0]   BULKY_RST     = 11'd512;
  localparam logic [WGT_W-1:0]   HEAVY_RST     = 11'd320;
  localparam logic [CAP_W-1:0]   CAPACITY_RST  = 16'd2560;

  localparam logic [CLASS_W-1:0] CLASS_VALUABLE_A = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_VALUABLE_B = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RESERVED_SHELF,
    REG_BULK_LIMIT,
    REG_HEAVY_LIMIT,
    REG_BIN_CAPACITY
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_PLACED,
    STAT_ZERO_VOLUME,
    STAT_NO_ROOM
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CAP_W-1:0]   occupied;
    logic [COUNT_W-1:0] count;
  } bin_entry_t;

  typedef struct packed {
    logic             take;
    logic [CAP_W-1:0] room;
  } fit_t;

endpackage

FILE: sv/ssa_channels.sv
// Request and response channel interfaces of the shelf slot allocator.
// Depends on ssa_pkg for the field widths.
interface ssa_req_if import ssa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] item_class;
  logic [VOL_W-1:0]   item_volume;
  logic [WGT_W-1:0]   item_weight;

  modport source (output valid, item_class, item_volume, item_weight, input ready);
  modport sink (input valid, item_class, item_volume, item_weight, output ready);
endinterface

interface ssa_rsp_if import ssa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SHELF_W-1:0]  shelf_index;
  logic [LEVEL_W-1:0]  level_index;
  logic [COUNT_W-1:0]  slot_sequence;

  modport source (output valid, status, shelf_index, level_index, slot_sequence, input ready);
  modport sink (input valid, status, shelf_index, level_index, slot_sequence, output ready);
endinterface

FILE: sv/ssa_bin_store.sv
// Bin state memory: occupied volume and item count per bin, registered read.
// Depends on ssa_pkg for bin_entry_t.
module ssa_bin_store import ssa_pkg::*; #(
  parameter int DEPTH = NUM_SHELVES_DEF * NUM_LEVELS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output bin_entry_t    rd_data,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  bin_entry_t    wr_data
);

  bin_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/ssa_fit_unit.sv
// Shared fit unit: room test, free room and best-bin decision for one bin a cycle.
// Depends on ssa_pkg for bin_entry_t and fit_t.
module ssa_fit_unit import ssa_pkg::*; (
  input  bin_entry_t       entry,
  input  logic [VOL_W-1:0] volume,
  input  logic [CAP_W-1:0] capacity,
  input  logic             eligible,
  input  logic             found,
  input  logic             worst,
  input  logic [CAP_W-1:0] best_room,
  output fit_t             fit
);

  logic [CAP_W:0]   total;
  logic             fits;
  logic [CAP_W-1:0] room;

  always_comb begin
    total    = {1'b0, entry.occupied} + (CAP_W+1)'(volume);
    fits     = total <= {1'b0, capacity};
    room     = capacity - entry.occupied;
    fit.room = room;
    fit.take = eligible && fits && (!found || (worst && (room > best_room)));
  end

endmodule

FILE: sv/shelf_slot_allocator.sv
// Shelf slot allocator: places items into a grid of shelves by levels of equal bins.
// Depends on ssa_pkg, ssa_channels, ssa_bin_store and ssa_fit_unit.
//
// Requests arrive on req (valid/ready): item class, volume and weight. Each
// accepted beat yields exactly one beat on rsp: status, shelf, level and the
// bin's new item count. The user must write registers through cfg_we/cfg_index/
// cfg_data only while no request is in flight; the block does not enforce this.
// After acceptance the sequencer reads the bin memory level by level while the
// shared fit unit tests one bin a cycle; the drain state then empties the read
// pipeline, the update state writes the chosen bin if one was found, and the
// done state loads the output register once it is free. A zero volume skips
// the scan and goes from idle straight to the done state.
// req.ready is high only while idle, so one item is in work at a time.
// After reset a clearing pass over all NUM_SHELVES * NUM_LEVELS bins zeroes the
// bin memory; req.ready stays low meanwhile, register writes are taken.
// A response waits in the output register while rsp.ready is low; the next
// request is still accepted, and its result holds until the register frees.
module shelf_slot_allocator import ssa_pkg::*; #(
  parameter int NUM_SHELVES = NUM_SHELVES_DEF,
  parameter int NUM_LEVELS  = NUM_LEVELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ssa_req_if.sink                req,
  ssa_rsp_if.source              rsp
);

  localparam int NUM_BINS = NUM_SHELVES * NUM_LEVELS;
  localparam int AW       = $clog2(NUM_BINS);
  localparam int SW       = $clog2(NUM_SHELVES);
  localparam int LW       = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CMPW     = (SW > SHELF_W) ? SW : SHELF_W;
  localparam int LXW      = (LW > LEVEL_W) ? LW : LEVEL_W;

  logic [SHELF_W-1:0] reserved_shelf;
  logic [VOL_W-1:0]   bulk_limit;
  logic [WGT_W-1:0]   heavy_limit;
  logic [CAP_W-1:0]   bin_capacity;

  state_t state, state_next;

  logic [AW-1:0]    addr;
  logic [SW-1:0]    scan_s;
  logic [LW-1:0]    scan_l;
  logic             scan_last;
  logic             eval_valid;
  logic [SW-1:0]    eval_s;
  logic [LW-1:0]    eval_l;
  logic [AW-1:0]    eval_addr;

  logic [VOL_W-1:0] it_vol;
  logic             it_valuable;
  logic             it_worst;

  logic             found;
  logic [SW-1:0]    best_s;
  logic [LW-1:0]    best_l;
  logic [AW-1:0]    best_addr;
  logic [CAP_W-1:0] best_room;
  bin_entry_t       best_entry;

  status_t            res_status;
  logic               res_placed;
  logic [COUNT_W-1:0] res_count;

  logic               rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [SHELF_W-1:0] rsp_shelf;
  logic [LEVEL_W-1:0] rsp_level;
  logic [COUNT_W-1:0] rsp_count;

  logic       req_accept;
  logic       zero_volume;
  logic       mem_we;
  logic [AW-1:0] mem_wr_addr;
  bin_entry_t mem_wr_data;
  bin_entry_t rd_data;
  bin_entry_t new_entry;
  logic       scan_issue;
  logic       out_load;
  logic       on_reserved;
  logic       eligible;
  fit_t       fit;

  logic [CMPW-1:0] shelf_wide;
  logic [LXW-1:0]  level_wide;

  ssa_bin_store #(
    .DEPTH (NUM_BINS)
  ) u_store (
    .clk     (clk),
    .rd_addr (addr),
    .rd_data (rd_data),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign on_reserved = CMPW'(eval_s) == CMPW'(reserved_shelf);
  assign eligible    = eval_valid && (it_valuable ? on_reserved : !on_reserved);

  ssa_fit_unit u_fit (
    .entry     (rd_data),
    .volume    (it_vol),
    .capacity  (bin_capacity),
    .eligible  (eligible),
    .found     (found),
    .worst     (it_worst),
    .best_room (best_room),
    .fit       (fit)
  );

  assign zero_volume = req.item_volume == '0;
  assign scan_last   = (scan_s == SW'(NUM_SHELVES - 1)) && (scan_l == LW'(NUM_LEVELS - 1));

  always_comb begin
    new_entry.occupied = best_entry.occupied + CAP_W'(it_vol);
    new_entry.count    = (best_entry.count < COUNT_MAX) ? best_entry.count + COUNT_W'(1)
                                                        : best_entry.count;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_shelf <= RESERVED_RST;
      bulk_limit     <= BULKY_RST;
      heavy_limit    <= HEAVY_RST;
      bin_capacity   <= CAPACITY_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RESERVED_SHELF: reserved_shelf <= cfg_data[SHELF_W-1:0];
        REG_BULK_LIMIT:     bulk_limit     <= cfg_data[VOL_W-1:0];
        REG_HEAVY_LIMIT:    heavy_limit    <= cfg_data[WGT_W-1:0];
        REG_BIN_CAPACITY:   bin_capacity   <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (addr == AW'(NUM_BINS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid) state_next = zero_volume ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = (found || fit.take) ? ST_UPDATE : ST_DONE;
      end
      ST_UPDATE: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid || rsp.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req.ready   = 1'b0;
    mem_we      = 1'b0;
    mem_wr_addr = best_addr;
    mem_wr_data = new_entry;
    scan_issue  = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wr_addr = addr;
        mem_wr_data = '0;
      end
      ST_IDLE:   req.ready  = 1'b1;
      ST_SCAN:   scan_issue = 1'b1;
      ST_UPDATE: mem_we     = 1'b1;
      ST_DONE:   out_load   = !rsp_valid || rsp.ready;
      default: ;
    endcase
  end

  assign req_accept = req.valid && req.ready;

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      eval_valid <= 1'b0;
      found      <= 1'b0;
    end else begin
      eval_valid <= scan_issue;
      case (state)
        ST_CLEAR: addr <= addr + AW'(1);
        ST_IDLE: begin
          if (req_accept) begin
            addr      <= '0;
            found     <= 1'b0;
            best_room <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_s == SW'(NUM_SHELVES - 1)) begin
            addr <= AW'(scan_l) + AW'(1);
          end else begin
            addr <= addr + AW'(NUM_LEVELS);
          end
        end
        default: ;
      endcase
      if (fit.take) begin
        found     <= 1'b1;
        best_room <= fit.room;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_s    <= scan_s;
    eval_l    <= scan_l;
    eval_addr <= addr;
    if (fit.take) begin
      best_s     <= eval_s;
      best_l     <= eval_l;
      best_addr  <= eval_addr;
      best_entry <= rd_data;
    end
    case (state)
      ST_IDLE: begin
        scan_s      <= '0;
        scan_l      <= '0;
        it_vol      <= req.item_volume;
        it_valuable <= (req.item_class == CLASS_VALUABLE_A) ||
                       (req.item_class == CLASS_VALUABLE_B);
        it_worst    <= !((req.item_class == CLASS_VALUABLE_A) ||
                         (req.item_class == CLASS_VALUABLE_B)) &&
                       ((req.item_volume > bulk_limit) || (req.item_weight > heavy_limit));
        res_status  <= STAT_ZERO_VOLUME;
        res_placed  <= 1'b0;
        res_count   <= '0;
      end
      ST_SCAN: begin
        if (scan_s == SW'(NUM_SHELVES - 1)) begin
          scan_s <= '0;
          scan_l <= scan_l + LW'(1);
        end else begin
          scan_s <= scan_s + SW'(1);
        end
      end
      ST_DRAIN: begin
        if (!(found || fit.take)) res_status <= STAT_NO_ROOM;
      end
      ST_UPDATE: begin
        res_status <= STAT_PLACED;
        res_placed <= 1'b1;
        res_count  <= new_entry.count;
      end
      default: ;
    endcase
  end

  assign shelf_wide = CMPW'(best_s);
  assign level_wide = LXW'(best_l);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_status <= res_status;
      rsp_shelf  <= res_placed ? shelf_wide[SHELF_W-1:0] : '0;
      rsp_level  <= res_placed ? level_wide[LEVEL_W-1:0] : '0;
      rsp_count  <= res_count;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.shelf_index   = rsp_shelf;
  assign rsp.level_index   = rsp_level;
  assign rsp.slot_sequence = rsp_count;

  a_zero_volume_skips_scan: assert property (@(posedge clk) disable iff (rst)
    req_accept && zero_volume |=> state == ST_DONE)
    else $error("zero volume beat entered the scan");

  a_placed_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == STAT_PLACED |-> rsp.slot_sequence != '0)
    else $error("placed beat with zero item count");

  a_unplaced_fields_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != STAT_PLACED |->
      rsp.shelf_index == '0 && rsp.level_index == '0 && rsp.slot_sequence == '0)
    else $error("unplaced beat carries a bin position");

  a_eval_in_scan: assert property (@(posedge clk) disable iff (rst)
    eval_valid |-> state == ST_SCAN || state == ST_DRAIN)
    else $error("fit evaluation outside the scan");

  a_write_after_found: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |-> found)
    else $error("bin update without a chosen bin");

endmodule
